// File: rtl/lap_pkg.sv
// lap_pkg: shared constants, codes and types of the 3x3 laplacian sharpen unit
// no dependencies
package lap_pkg;

  localparam int LINE_SAMPLES = 4096;
  localparam int POS_W        = $clog2(LINE_SAMPLES);
  localparam int LEN_W        = POS_W + 1;
  localparam int SAMPLE_W     = 8;
  localparam int DIM_W        = 13;
  localparam int CH_W         = 3;
  localparam int CFG_IDX_W    = 2;

  localparam logic [DIM_W-1:0] COLS_MIN  = DIM_W'(3);
  localparam logic [DIM_W-1:0] COLS_MAX  = DIM_W'(4096);
  localparam logic [DIM_W-1:0] ROWS_MIN  = DIM_W'(3);
  localparam logic [DIM_W-1:0] ROWS_MAX  = DIM_W'(4096);
  localparam logic [CH_W-1:0]  CH_MIN    = CH_W'(1);
  localparam logic [CH_W-1:0]  CH_MAX    = CH_W'(4);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(640);
  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(480);
  localparam logic [CH_W-1:0]  CH_RESET   = CH_W'(1);

  // history of centre samples, one per possible channel distance
  localparam int HIST_DEPTH = 4;
  localparam int HIST_W     = $clog2(HIST_DEPTH);

  // result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS     = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] down;
    logic [CH_W-1:0]     ch;
    logic                row_ge1;
    logic                row_ge2;
    logic                last_row;
    logic                interior;
    logic                last_pos;
  } stage_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sharpened;
    logic                frame_end;
    logic                run_last;
  } result_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

// File: rtl/lap_ram.sv
// lap_ram: generic single write port, single read port ram with registered read
// no dependencies
module lap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lap_kernel.sv
// lap_kernel: 5-point laplacian sharpen with clamp and result formation
// depends on lap_pkg
module lap_kernel import lap_pkg::*; (
  input  logic                valid,
  input  stage_t              item,
  input  logic [SAMPLE_W-1:0] cen,
  input  logic [SAMPLE_W-1:0] up,
  input  logic [SAMPLE_W-1:0] left,
  input  logic [SAMPLE_W-1:0] right,
  output push_t               push,
  output result_t             res0,
  output result_t             res1
);

  logic [10:0]         five;
  logic [9:0]          neigh;
  logic signed [11:0]  diff;
  logic [SAMPLE_W-1:0] val;

  always_comb begin
    five  = 11'({cen, 2'b00}) + 11'(cen);
    neigh = 10'(left) + 10'(right) + 10'(up) + 10'(item.down);
    diff  = $signed({1'b0, five}) - $signed({2'b00, neigh});
    if (!(item.row_ge2 && item.interior) || diff < 0) begin
      val = '0;
    end else if (diff > 12'sd255) begin
      val = '1;
    end else begin
      val = diff[SAMPLE_W-1:0];
    end

    res0.sharpened = val;
    res0.frame_end = 1'b0;
    res0.run_last  = !item.last_row;

    // final row also emits its own border result
    res1.sharpened = '0;
    res1.frame_end = item.last_pos;
    res1.run_last  = 1'b1;

    push.push0 = valid && item.row_ge1;
    push.push1 = valid && item.row_ge1 && item.last_row;
  end

endmodule

// File: rtl/lap_queue.sv
// lap_queue: result queue taking up to two results per cycle, one out per cycle
// depends on lap_pkg
module lap_queue import lap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  result_t           din0,
  input  result_t           din1,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           dout,
  output logic [QCNT_W-1:0] count
);

  result_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;
  logic [QCNT_W-1:0] n_push;

  assign out_valid = (count != '0);
  assign dout      = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = QCNT_W'(push.push0) + QCNT_W'(push.push1);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push.push1) begin
      mem[wr_ptr + QPTR_W'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + n_push - QCNT_W'(pop);
    end
  end

endmodule

// File: rtl/laplacian_sharpen_3x3_unit.sv
// laplacian_sharpen_3x3_unit: top level of the 3x3 laplacian sharpen filter
// depends on lap_pkg, lap_ram, lap_kernel, lap_queue
// path: a sample is registered in the stage register, and its result in the
//   result queue, before the result is offered on the output
// throughput: one sample per cycle while the result queue has room, set by the line store read in the transfer
//   cycle and the kernel in the next; final-row samples give two results,
//   which leave at one per cycle through the result queue, so the input is then
//   held back by sample_ready while the queue lacks room for them
// reset: rst clears counters, queue and registers to 640 x 480, one channel;
//   line stores are not cleared and need no clearing pass
module laplacian_sharpen_3x3_unit import lap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  // sample input channel
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  // result output channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [SAMPLE_W-1:0]  sharpened,
  output logic                 frame_end,
  output logic                 run_last
);

  // configuration registers
  logic [DIM_W-1:0] image_cols;
  logic [DIM_W-1:0] image_rows;
  logic [CH_W-1:0]  channel_count;

  // frame position of the next sample
  logic [POS_W-1:0] sample_position;
  logic [POS_W-1:0] row_position;

  // saturated configuration
  logic [DIM_W-1:0]   cols_c;
  logic [DIM_W-1:0]   rows_c;
  logic [CH_W-1:0]    ch_c;
  logic [DIM_W+CH_W-1:0] len_full;
  logic [LEN_W-1:0]   len;

  logic cfg_fire;
  logic in_fire;

  // stage register between line store read and kernel
  logic   stage_valid;
  stage_t stage;
  stage_t stage_next;
  logic [POS_W-1:0] stage_pos;

  // line store addresses and data
  logic [POS_W-1:0]    right_addr;
  logic [SAMPLE_W-1:0] up_data;
  logic [SAMPLE_W-1:0] cen_data;
  logic [SAMPLE_W-1:0] right_data;
  logic [SAMPLE_W-1:0] left_data;

  // centre samples of the last few positions, for the left neighbour
  logic [SAMPLE_W-1:0] hist [HIST_DEPTH];
  logic [CH_W-1:0]     hist_sel;

  push_t             push;
  result_t           res0;
  result_t           res1;
  result_t           q_out;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W+1:0] q_need;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = sample_valid && sample_ready;

  always_comb begin
    if (image_cols < COLS_MIN) begin
      cols_c = COLS_MIN;
    end else if (image_cols > COLS_MAX) begin
      cols_c = COLS_MAX;
    end else begin
      cols_c = image_cols;
    end
    if (image_rows < ROWS_MIN) begin
      rows_c = ROWS_MIN;
    end else if (image_rows > ROWS_MAX) begin
      rows_c = ROWS_MAX;
    end else begin
      rows_c = image_rows;
    end
    if (channel_count < CH_MIN) begin
      ch_c = CH_MIN;
    end else if (channel_count > CH_MAX) begin
      ch_c = CH_MAX;
    end else begin
      ch_c = channel_count;
    end
    // row length in samples, limited to the line store
    len_full = (DIM_W+CH_W)'(cols_c) * (DIM_W+CH_W)'(ch_c);
    if (len_full > (DIM_W+CH_W)'(LINE_SAMPLES)) begin
      len = LEN_W'(LINE_SAMPLES);
    end else begin
      len = len_full[LEN_W-1:0];
    end
  end

  // classify the arriving sample against the current position
  always_comb begin
    stage_next.down     = sample;
    stage_next.ch       = ch_c;
    stage_next.row_ge1  = (row_position != '0);
    stage_next.row_ge2  = (row_position > POS_W'(1));
    stage_next.last_row = (DIM_W'(row_position) == rows_c - DIM_W'(1));
    stage_next.interior = (LEN_W'(sample_position) >= LEN_W'(ch_c)) &&
                          (LEN_W'(sample_position) + LEN_W'(ch_c) < len);
    stage_next.last_pos = (LEN_W'(sample_position) == len - LEN_W'(1));
    // out of row addresses only feed border results
    right_addr = sample_position + POS_W'(ch_c);
  end

  // configuration writes; any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols    <= COLS_RESET;
      image_rows    <= ROWS_RESET;
      channel_count <= CH_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_COLS:     image_cols    <= cfg_data;
        CFG_ROWS:     image_rows    <= cfg_data;
        CFG_CHANNELS: channel_count <= cfg_data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      sample_position <= '0;
      row_position    <= '0;
    end else if (in_fire) begin
      if (LEN_W'(sample_position) + LEN_W'(1) >= len) begin
        sample_position <= '0;
        if (DIM_W'(row_position) + DIM_W'(1) >= rows_c) begin
          row_position <= '0;
        end else begin
          row_position <= row_position + POS_W'(1);
        end
      end else begin
        sample_position <= sample_position + POS_W'(1);
      end
    end
  end

  // stage register; the kernel never stalls since the queue has room reserved
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage     <= stage_next;
      stage_pos <= sample_position;
    end
  end

  // older line: two rows back, read at the centre position
  lap_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_SAMPLES)) u_older (
    .clk     (clk),
    .wr_en   (stage_valid),
    .wr_addr (stage_pos),
    .wr_data (cen_data),
    .rd_en   (in_fire),
    .rd_addr (sample_position),
    .rd_data (up_data)
  );

  // newer line, two copies: one read at the centre, one at the right neighbour
  lap_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_SAMPLES)) u_newer_cen (
    .clk     (clk),
    .wr_en   (stage_valid),
    .wr_addr (stage_pos),
    .wr_data (stage.down),
    .rd_en   (in_fire),
    .rd_addr (sample_position),
    .rd_data (cen_data)
  );

  lap_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_SAMPLES)) u_newer_right (
    .clk     (clk),
    .wr_en   (stage_valid),
    .wr_addr (stage_pos),
    .wr_data (stage.down),
    .rd_en   (in_fire),
    .rd_addr (right_addr),
    .rd_data (right_data)
  );

  // left neighbour is the centre sample seen one channel distance earlier
  always_ff @(posedge clk) begin
    if (stage_valid) begin
      hist[0] <= cen_data;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  assign hist_sel  = stage.ch - CH_W'(1);
  assign left_data = hist[hist_sel[HIST_W-1:0]];

  lap_kernel u_kernel (
    .valid (stage_valid),
    .item  (stage),
    .cen   (cen_data),
    .up    (up_data),
    .left  (left_data),
    .right (right_data),
    .push  (push),
    .res0  (res0),
    .res1  (res1)
  );

  lap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .dout      (q_out),
    .count     (q_count)
  );

  // room for two results of the staged sample and two of the new one
  assign q_need = (QCNT_W+2)'(q_count) + (stage_valid ? (QCNT_W+2)'(2) : '0) +
                  (QCNT_W+2)'(2);
  assign sample_ready = (q_need <= (QCNT_W+2)'(QUEUE_DEPTH));

  assign sharpened = q_out.sharpened;
  assign frame_end = q_out.frame_end;
  assign run_last  = q_out.run_last;

endmodule
